### rtl/pcmfc_pkg.sv
package pcmfc_pkg;

	// PCM formats held in the configuration register.
	typedef enum logic [1:0] {
		DEPTH_INT16   = 2'd0,
		DEPTH_INT24   = 2'd1,
		DEPTH_FLOAT32 = 2'd2,
		DEPTH_FLOAT64 = 2'd3
	} depth_t;

	// Operation carried in tuser with each request.
	typedef enum logic {
		CMD_ENCODE = 1'b0,
		CMD_DECODE = 1'b1
	} cmd_t;

	localparam int SAMPLE_W = 32;
	localparam int PCM_W    = 64;
	localparam int COUNT_W  = 4;

	localparam depth_t DEPTH_RESET = DEPTH_FLOAT32;

	// Load enables of the two pipeline stages inside the conversion units.
	typedef struct packed {
		logic s1;
		logic s2;
	} pipe_en_t;

	function automatic logic [COUNT_W-1:0] byte_count_of(depth_t d);
		logic [COUNT_W-1:0] n;
		case (d)
			DEPTH_INT16:   n = 4'd2;
			DEPTH_INT24:   n = 4'd3;
			DEPTH_FLOAT32: n = 4'd4;
			default:       n = 4'd8;
		endcase
		return n;
	endfunction

	// Leading zero count of a 24-bit word; 24 when the word is zero.
	function automatic logic [4:0] lzc24(logic [23:0] v);
		logic [4:0] n;
		logic       found;
		n = 5'd24;
		found = 1'b0;
		for (int i = 23; i >= 0; i--) begin
			if (!found && v[i]) begin
				n = 5'(23 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

endpackage

### rtl/pcm_sample_format_converter_unit.sv
// Channel    Direction  Payload
// s_axis     in         tdata: sample_in, pcm_in; tuser: cmd; tlast: end_of_block
// m_axis     out        tdata: sample_out, pcm_out, byte_count; tlast: last_out
// cfg        in         data: bit_depth
//
// Every request passes through the pipeline: two register stages inside
// the encoder and decoder and the output register. One request is taken per
// cycle unless a stall has backed up every stage; the three stages hold the float arithmetic.
// Reset clears the valid bits and sets the format to float32.
// A stalled output holds its result while bubbles in front of it are still filled;
// a stall reaches the input only once every stage is occupied.
module pcm_sample_format_converter_unit (
	input  logic         clk,
	input  logic         arst_n,

	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// From bit 0: sample_in [31:0], pcm_in [95:32].
	input  logic [95:0]  s_axis_tdata,
	// Bit 0: cmd.
	input  logic         s_axis_tuser,
	input  logic         s_axis_tlast,

	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// From bit 0: sample_out [31:0], pcm_out [95:32], byte_count [99:96], zero fill.
	output logic [103:0] m_axis_tdata,
	output logic         m_axis_tlast,

	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_data
);
	import pcmfc_pkg::*;

	// The format register. The user must write it only while the pipeline is empty, so
	// that every request in flight sees the same value; the block does not enforce it.
	depth_t bit_depth_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_depth_q <= DEPTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			bit_depth_q <= depth_t'(cfg_data);
		end
	end

	// Pipeline flow control. A stage may load whenever it is empty or the
	// stage after it is loading, which lets bubbles collapse under a stall.
	logic     valid_s1;
	logic     valid_s2;
	logic     en3;
	pipe_en_t en;

	assign en3          = !m_axis_tvalid || m_axis_tready;
	assign en.s2        = !valid_s2 || en3;
	assign en.s1        = !valid_s1 || en.s2;
	assign s_axis_tready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (en.s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (en.s2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				m_axis_tvalid <= valid_s2;
			end
		end
	end

	// Sideband that travels alongside the arithmetic.
	cmd_t                cmd_s1;
	cmd_t                cmd_s2;
	cmd_t                cmd_s3;
	logic                last_s1;
	logic                last_s2;
	logic [COUNT_W-1:0]  count_s1;
	logic [COUNT_W-1:0]  count_s2;
	logic [COUNT_W-1:0]  count_s3;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			cmd_s1   <= cmd_t'(s_axis_tuser);
			last_s1  <= s_axis_tlast;
			count_s1 <= byte_count_of(bit_depth_q);
		end
		if (en.s2) begin
			cmd_s2   <= cmd_s1;
			last_s2  <= last_s1;
			count_s2 <= count_s1;
		end
	end

	// Both directions are computed for every request; the command picks one.
	logic [PCM_W-1:0]    enc_pcm;
	logic [SAMPLE_W-1:0] dec_sample;

	pcmfc_enc u_enc (
		.clk    (clk),
		.en     (en),
		.depth  (bit_depth_q),
		.sample (s_axis_tdata[31:0]),
		.pcm    (enc_pcm)
	);

	pcmfc_dec u_dec (
		.clk    (clk),
		.en     (en),
		.depth  (bit_depth_q),
		.pcm    (s_axis_tdata[95:32]),
		.sample (dec_sample)
	);

	// Output register. The field not produced by the command reads as zero.
	logic [SAMPLE_W-1:0] sample_s3;
	logic [PCM_W-1:0]    pcm_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			cmd_s3       <= cmd_s2;
			sample_s3    <= (cmd_s2 == CMD_DECODE) ? dec_sample : '0;
			pcm_s3       <= (cmd_s2 == CMD_ENCODE) ? enc_pcm : '0;
			count_s3     <= count_s2;
			m_axis_tlast <= last_s2;
		end
	end

	assign m_axis_tdata = {4'd0, count_s3, pcm_s3, sample_s3};

	// The input may only be held off while the first stage holds a request.
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1)
		else $error("input stalled with an empty first stage");

	// A request in the second stage that cannot move on must not vanish.
	a_s2_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !en.s2 |=> valid_s2)
		else $error("stalled request lost in stage two");

	a_count_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (count_s3 == 4'd2 || count_s3 == 4'd3
			|| count_s3 == 4'd4 || count_s3 == 4'd8))
		else $error("byte count out of range");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && cmd_s3 == CMD_ENCODE |-> sample_s3 == '0)
		else $error("sample field not cleared on an encode result");

endmodule

### rtl/pcmfc_enc.sv
module pcmfc_enc (
	input  logic                clk,
	input  pcmfc_pkg::pipe_en_t en,
	input  pcmfc_pkg::depth_t   depth,
	input  logic [31:0]         sample,
	output logic [63:0]         pcm
);
	import pcmfc_pkg::*;

	// Stage 1: unpack and scale the significand by 32767.
	logic [23:0] mant_c;
	logic [38:0] prod_c;

	logic        sign_s1;
	logic [7:0]  ex_s1;
	logic [22:0] frac_s1;
	logic [38:0] prod_s1;
	depth_t      depth_s1;

	assign mant_c = {sample[30:23] != 8'd0, sample[22:0]};
	assign prod_c = {15'd0, mant_c} * 39'd32767;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			sign_s1  <= sample[31];
			ex_s1    <= sample[30:23];
			frac_s1  <= sample[22:0];
			prod_s1  <= prod_c;
			depth_s1 <= depth;
		end
	end

	// Stage 2: round the int16 product to single precision, then align the
	// magnitude to a fixed point word with one fractional bit.
	logic signed [9:0]  ev_c;
	logic [23:0]        sig_c;
	logic               grd_c;
	logic               stk_c;
	logic [24:0]        s16_c;
	logic [24:0]        s_c;
	logic signed [10:0] sh_c;
	logic signed [10:0] rs_c;
	logic [5:0]         rs6_c;
	logic [32:0]        q_c;
	logic               big_c;

	always_comb begin
		ev_c = (ex_s1 == 8'd0) ? -10'sd126 : ($signed({2'b00, ex_s1}) - 10'sd127);
		if (prod_s1[38]) begin
			sig_c = prod_s1[38:15];
			grd_c = prod_s1[14];
			stk_c = |prod_s1[13:0];
		end else begin
			sig_c = prod_s1[37:14];
			grd_c = prod_s1[13];
			stk_c = |prod_s1[12:0];
		end
		s16_c = {1'b0, sig_c} + {24'd0, grd_c & (stk_c | sig_c[0])};
		if (depth_s1 == DEPTH_INT16) begin
			s_c  = s16_c;
			sh_c = $signed({ev_c[9], ev_c}) + (prod_s1[38] ? 11'sd15 : 11'sd14) - 11'sd22;
		end else begin
			s_c  = {1'b0, ex_s1 != 8'd0, frac_s1};
			sh_c = $signed({ev_c[9], ev_c}) + 11'sd9;
		end
		big_c = sh_c > 11'sd8;
		rs_c  = 11'sd8 - sh_c;
		rs6_c = (rs_c > 11'sd63) ? 6'd63 : rs_c[5:0];
		q_c   = {s_c, 8'd0} >> rs6_c;
	end

	logic        sign_s2;
	logic [7:0]  ex_s2;
	logic [22:0] frac_s2;
	logic [32:0] q_s2;
	logic        big_s2;
	logic [4:0]  lz_s2;
	depth_t      depth_s2;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			sign_s2  <= sign_s1;
			ex_s2    <= ex_s1;
			frac_s2  <= frac_s1;
			q_s2     <= q_c;
			big_s2   <= big_c;
			lz_s2    <= lzc24({frac_s1, 1'b1});
			depth_s2 <= depth_s1;
		end
	end

	// Stage 3: truncate toward zero after the half offset, saturate, pack.
	logic [31:0] ii_c;
	logic [32:0] r_c;
	logic [32:0] m_c;
	logic [32:0] mag_c;
	logic [32:0] lim_c;
	logic [32:0] magc_c;
	logic [31:0] v_c;
	logic        nan_c;
	logic [22:0] fs_c;
	logic [63:0] wide_c;

	always_comb begin
		ii_c  = q_s2[32:1];
		r_c   = {1'b0, ii_c} + {32'd0, q_s2[0]} + {32'd0, (|ii_c[31:23]) & ii_c[0]};
		if (ii_c == 32'd0 && !q_s2[0]) begin
			m_c = 33'd0;
		end else begin
			m_c = {1'b0, ii_c} - 33'd1
				+ {32'd0, (ii_c > 32'h0080_0000) ? !ii_c[0] : q_s2[0]};
		end
		mag_c = sign_s2 ? m_c : r_c;
		if (depth_s2 == DEPTH_INT16) begin
			lim_c = sign_s2 ? 33'd32768 : 33'd32767;
		end else begin
			lim_c = sign_s2 ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
		end
		magc_c = (big_s2 || mag_c >= lim_c) ? lim_c : mag_c;
		nan_c  = (ex_s2 == 8'hFF) && (frac_s2 != 23'd0);
		if (nan_c) begin
			v_c = 32'd0;
		end else begin
			v_c = sign_s2 ? (32'd0 - magc_c[31:0]) : magc_c[31:0];
		end

		// Widening to double precision; subnormal inputs are normalised.
		fs_c = frac_s2 << (lz_s2 + 5'd1);
		if (ex_s2 == 8'hFF) begin
			wide_c = nan_c ? {sign_s2, 11'h7FF, 1'b1, frac_s2[21:0], 29'd0}
				: {sign_s2, 11'h7FF, 52'd0};
		end else if (ex_s2 == 8'd0) begin
			wide_c = (frac_s2 == 23'd0) ? {sign_s2, 63'd0}
				: {sign_s2, 11'd896 - {6'd0, lz_s2}, fs_c, 29'd0};
		end else begin
			wide_c = {sign_s2, {3'd0, ex_s2} + 11'd896, frac_s2, 29'd0};
		end

		case (depth_s2)
			DEPTH_INT16:   pcm = {v_c[15:0], 48'd0};
			DEPTH_INT24:   pcm = {v_c[31:8], 40'd0};
			DEPTH_FLOAT32: pcm = {sign_s2, ex_s2, frac_s2, 32'd0};
			default:       pcm = wide_c;
		endcase
	end

endmodule

### rtl/pcmfc_dec.sv
module pcmfc_dec (
	input  logic                clk,
	input  pcmfc_pkg::pipe_en_t en,
	input  pcmfc_pkg::depth_t   depth,
	input  logic [63:0]         pcm,
	output logic [31:0]         sample
);
	import pcmfc_pkg::*;

	// Stage 1: sign and magnitude of the integer, classification and
	// right shift amount of the double.
	logic [23:0] v_c;
	logic [23:0] mag_c;
	logic [10:0] de_c;
	logic [10:0] dist_c;
	logic        norm_c;

	always_comb begin
		v_c    = (depth == DEPTH_INT16) ? {{8{pcm[63]}}, pcm[63:48]} : pcm[63:40];
		mag_c  = v_c[23] ? (24'd0 - v_c) : v_c;
		de_c   = pcm[62:52];
		norm_c = de_c >= 11'd897;
		dist_c = 11'd926 - de_c;
	end

	logic [23:0] mag_s1;
	logic        neg_s1;
	depth_t      depth_s1;
	logic        sign_s1;
	logic        nan_s1;
	logic        inf_s1;
	logic [52:0] m53_s1;
	logic [5:0]  sa_s1;
	logic [7:0]  expf_s1;
	logic [21:0] pay_s1;
	logic [31:0] word_s1;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			mag_s1   <= mag_c;
			neg_s1   <= v_c[23];
			depth_s1 <= depth;
			sign_s1  <= pcm[63];
			nan_s1   <= (de_c == 11'h7FF) && (pcm[51:0] != 52'd0);
			inf_s1   <= (de_c == 11'h7FF && pcm[51:0] == 52'd0)
				|| (de_c != 11'h7FF && de_c > 11'd1150);
			m53_s1   <= {de_c != 11'd0, pcm[51:0]};
			sa_s1    <= norm_c ? 6'd29 : ((dist_c > 11'd63) ? 6'd63 : dist_c[5:0]);
			expf_s1  <= norm_c ? 8'(de_c - 11'd896) : 8'd0;
			pay_s1   <= pcm[50:29];
			word_s1  <= pcm[63:32];
		end
	end

	// Stage 2: leading zero count of the integer, alignment of the double.
	logic [115:0] wide_c;

	assign wide_c = {m53_s1, 63'd0} >> sa_s1;

	logic [23:0] mag_s2;
	logic [4:0]  lz_s2;
	logic        neg_s2;
	depth_t      depth_s2;
	logic        sign_s2;
	logic        nan_s2;
	logic        inf_s2;
	logic [22:0] rr_s2;
	logic        rnd_s2;
	logic [7:0]  expf_s2;
	logic [21:0] pay_s2;
	logic [31:0] word_s2;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			mag_s2   <= mag_s1;
			lz_s2    <= lzc24(mag_s1);
			neg_s2   <= neg_s1;
			depth_s2 <= depth_s1;
			sign_s2  <= sign_s1;
			nan_s2   <= nan_s1;
			inf_s2   <= inf_s1;
			rr_s2    <= wide_c[85:63];
			rnd_s2   <= wide_c[62] & ((|wide_c[61:0]) | wide_c[63]);
			expf_s2  <= expf_s1;
			pay_s2   <= pay_s1;
			word_s2  <= word_s1;
		end
	end

	// Stage 3: normalise the integer (exact) and round the double to nearest
	// even; a mantissa carry moves into the exponent field by itself.
	logic [23:0] norm_mag_c;
	logic [7:0]  e8_c;
	logic [31:0] int_c;
	logic [31:0] nar_c;

	always_comb begin
		norm_mag_c = mag_s2 << lz_s2;
		e8_c = ((depth_s2 == DEPTH_INT16) ? 8'd135 : 8'd127) - {3'd0, lz_s2};
		int_c = (mag_s2 == 24'd0) ? 32'd0 : {neg_s2, e8_c, norm_mag_c[22:0]};
		if (nan_s2) begin
			nar_c = {sign_s2, 8'hFF, 1'b1, pay_s2};
		end else if (inf_s2) begin
			nar_c = {sign_s2, 8'hFF, 23'd0};
		end else begin
			nar_c = {sign_s2, {expf_s2, rr_s2} + {30'd0, rnd_s2}};
		end
		case (depth_s2)
			DEPTH_INT16:   sample = int_c;
			DEPTH_INT24:   sample = int_c;
			DEPTH_FLOAT32: sample = word_s2;
			default:       sample = nar_c;
		endcase
	end

endmodule

### sim/pcm_conversion_checker.sv
module pcm_conversion_checker
	import pcmfc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [95:0]  s_axis_tdata,
	input  logic         s_axis_tuser,
	input  logic         s_axis_tlast,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [103:0] m_axis_tdata,
	input  logic         m_axis_tlast,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [1:0]   cfg_data,
	output int           fail_count,
	output int           pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [PCM_W-1:0]    pcm;
		logic [COUNT_W-1:0]  count;
		logic                last;
	} converted_t;

	converted_t awaited_samples[$];
	depth_t     depth;

	// Rounds a double to the nearest single, ties to even, with subnormals and overflow.
	function automatic logic [31:0] round_to_single(real r);
		logic [63:0] d;
		logic [63:0] m;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] half;
		logic        sgn;
		int          e;
		int          sh;
		d = $realtobits(r);
		sgn = d[63];
		if (d[62:52] == 11'h7FF) begin
			return (d[51:0] != 0) ? {sgn, 8'hFF, 23'h400000} : {sgn, 8'hFF, 23'h0};
		end
		if (d[62:52] == 11'h0)
			return {sgn, 31'h0};
		e = int'(d[62:52]) - 1023 + 127;
		m = {11'h0, 1'b1, d[51:0]};
		sh = (e >= 1) ? 29 : 30 - e;
		if (sh > 60)
			return {sgn, 31'h0};
		q = m >> sh;
		rem = m & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && q[0]))
			q = q + 64'd1;
		if (e >= 1) begin
			if (q[24]) begin
				q = q >> 1;
				e++;
			end
			if (e >= 255)
				return {sgn, 8'hFF, 23'h0};
			return {sgn, 8'(e), q[22:0]};
		end
		// A subnormal that rounds up into the smallest normal carries into the exponent.
		return {sgn, q[30:0]};
	endfunction

	// Exact widening of single to double; NaNs become quiet and keep their payload.
	function automatic logic [63:0] widen_single(logic [31:0] u);
		logic [23:0] m;
		int          ex;
		if (u[30:23] == 8'hFF) begin
			if (u[22:0] != 0)
				return {u[31], 11'h7FF, 52'h8000000000000 | (52'(u[22:0]) << 29)};
			return {u[31], 11'h7FF, 52'h0};
		end
		if (u[30:23] == 8'h0) begin
			if (u[22:0] == 0)
				return {u[31], 63'h0};
			m = {1'b0, u[22:0]};
			ex = -126;
			while (!m[23]) begin
				m = m << 1;
				ex--;
			end
			return {u[31], 11'(ex + 1023), m[22:0], 29'h0};
		end
		return {u[31], 11'(int'(u[30:23]) - 127 + 1023), u[22:0], 29'h0};
	endfunction

	function automatic real single_value(logic [31:0] u);
		return $bitstoreal(widen_single(u));
	endfunction

	function automatic logic is_nan(logic [31:0] u);
		return u[30:23] == 8'hFF && u[22:0] != 0;
	endfunction

	function automatic converted_t convert_sample(depth_t dp, cmd_t cmd, logic [31:0] smp,
			logic [63:0] pcm, logic last);
		converted_t  c;
		logic [31:0] p;
		logic [31:0] t;
		logic [31:0] v;
		real         tr;
		c = '0;
		c.count = byte_count_of(dp);
		c.last = last;
		if (cmd == CMD_ENCODE) begin
			case (dp)
				DEPTH_INT16, DEPTH_INT24: begin
					// Scale and add the half in single precision, one rounding per step.
					p = round_to_single(single_value(smp) *
						((dp == DEPTH_INT16) ? 32767.0 : 2147483648.0));
					t = is_nan(p) ? p : round_to_single(single_value(p) + 0.5);
					tr = single_value(t);
					if (is_nan(t))
						v = 0;
					else if (dp == DEPTH_INT16) begin
						if (tr >= 32767.0)
							v = 32767;
						else if (tr <= -32768.0)
							v = -32768;
						else
							v = $rtoi(tr);
						c.pcm = {v[15:0], 48'h0};
					end else begin
						if (tr >= 2147483648.0)
							v = 32'h7FFFFFFF;
						else if (tr <= -2147483648.0)
							v = 32'h80000000;
						else
							v = $rtoi(tr);
						c.pcm = {v[31:8], 40'h0};
					end
				end
				DEPTH_FLOAT32: c.pcm = {smp, 32'h0};
				default:       c.pcm = widen_single(smp);
			endcase
		end else begin
			case (dp)
				DEPTH_INT16:   c.sample = round_to_single(
					real'($signed(pcm[63:48])) / 32768.0);
				DEPTH_INT24:   c.sample = round_to_single(
					real'($signed(pcm[63:40])) / 8388608.0);
				DEPTH_FLOAT32: c.sample = pcm[63:32];
				default: begin
					if (pcm[62:52] == 11'h7FF && pcm[51:0] != 0)
						c.sample = {pcm[63], 31'h7FC00000 | 31'(pcm[50:29])};
					else
						c.sample = round_to_single($bitstoreal(pcm));
				end
			endcase
		end
		return c;
	endfunction

	assign pending_count = awaited_samples.size();

	// Channels are sampled on the falling edge ahead of the rising edge that completes each handshake.
	always @(negedge clk or negedge arst_n) begin
		converted_t want;
		converted_t got;
		int         errs;
		if (!arst_n) begin
			depth <= DEPTH_RESET;
			fail_count <= 0;
		end else begin
			errs = 0;
			if (m_axis_tvalid && m_axis_tready) begin
				got.sample = m_axis_tdata[31:0];
				got.pcm = m_axis_tdata[95:32];
				got.count = m_axis_tdata[99:96];
				got.last = m_axis_tlast;
				if (awaited_samples.size() == 0) begin
					$display("%0t: unexpected result, actual %h", $time, got);
					errs++;
				end else begin
					want = awaited_samples.pop_front();
					if (got.sample !== want.sample) begin
						$display("%0t: sample_out expected %h actual %h", $time, want.sample,
							got.sample);
						errs++;
					end
					if (got.pcm !== want.pcm) begin
						$display("%0t: pcm_out expected %h actual %h", $time, want.pcm,
							got.pcm);
						errs++;
					end
					if (got.count !== want.count) begin
						$display("%0t: byte_count expected %0d actual %0d", $time,
							want.count, got.count);
						errs++;
					end
					if (got.last !== want.last) begin
						$display("%0t: last_out expected %b actual %b", $time, want.last,
							got.last);
						errs++;
					end
					if (m_axis_tdata[103:100] !== 4'h0) begin
						$display("%0t: fill bits expected 0 actual %h", $time,
							m_axis_tdata[103:100]);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			if (s_axis_tvalid && s_axis_tready)
				awaited_samples.push_back(convert_sample(depth, cmd_t'(s_axis_tuser),
					s_axis_tdata[31:0], s_axis_tdata[95:32], s_axis_tlast));
			if (cfg_valid && cfg_ready)
				depth <= depth_t'(cfg_data);
		end
	end

endmodule

### sim/tb.sv
module tb;
	import pcmfc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Generous ceiling on the run length for roughly two thousand requests.
	localparam int CYCLE_LIMIT = 300000;
	localparam int ITEMS_PER_SETTING = 120;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [95:0]  s_axis_tdata;
	logic         s_axis_tuser;
	logic         s_axis_tlast;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [103:0] m_axis_tdata;
	logic         m_axis_tlast;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_data;
	int           fail_count;
	int           pending_count;
	int           cycles;
	int           send_idle_pct;
	int           recv_stall_pct;

	pcm_sample_format_converter_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	pcm_conversion_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The watchdog ends a run that goes past the cycle limit.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// The receiver draws a fresh ready every cycle, stalling with the phase's probability.
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	// Sends one request, after a random number of idle cycles. Ready is looked at on the
	// falling edge, where it has settled for the edge that follows.
	task automatic send_request(cmd_t cmd, logic [31:0] smp, logic [63:0] pcm, logic last);
		logic rdy;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {pcm, smp};
		s_axis_tuser <= cmd;
		s_axis_tlast <= last;
		do begin
			@(negedge clk);
			rdy = s_axis_tready;
			@(posedge clk);
		end while (!rdy);
	endtask

	// The format may only change once the pipeline has drained completely.
	task automatic set_depth(depth_t dp);
		logic rdy;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= dp;
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
		cfg_valid <= 1'b0;
	endtask

	// Mostly audio-range magnitudes, with raw bit patterns and the odd special value.
	function automatic logic [31:0] random_sample();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(9))
			0, 1: ;
			2, 3, 4, 5: r[30:23] = 8'($urandom_range(128, 100));
			6, 7: r[30:23] = 8'($urandom_range(127, 113));
			8: r[30:23] = ($urandom_range(1)) ? 8'hFF : 8'h00;
			default: r[30:0] = ($urandom_range(1)) ? 31'h3F800000 : 31'h0;
		endcase
		return r;
	endfunction

	// Double patterns are kept near the single range half of the time so that rounding
	// on the way back is exercised rather than only overflow and underflow.
	function automatic logic [63:0] random_pcm();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(3))
			0: ;
			1, 2: r[62:52] = 11'($urandom_range(1023 + 130, 1023 - 152));
			default: r[62:52] = ($urandom_range(1)) ? 11'h7FF : 11'h0;
		endcase
		return r;
	endfunction

	logic [31:0] edge_samples[12] = '{
		32'h00000000, 32'h80000000, 32'h3F800000, 32'hBF800000,
		32'h7F800000, 32'hFF800000, 32'h7FC00000, 32'hFFA5A5A5,
		32'h3F000000, 32'h501502F9, 32'h00000001, 32'h7F7FFFFF
	};
	logic [63:0] edge_pcm[8] = '{
		64'h0000000000000000, 64'h8000000000000000, 64'h7FFFFFFFFFFFFFFF,
		64'hFFFFFFFFFFFFFFFF, 64'h7FF0000000000001, 64'hFFF0000000000000,
		64'h000FFFFFFFFFFFFF, 64'h3FF0000010000000
	};

	int idle_modes[4][2] = '{'{0, 0}, '{55, 0}, '{0, 55}, '{32, 32}};

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = DEPTH_RESET;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: extreme and special values through every format, starting from the
		// reset format so that the reset value of the register is checked first.
		for (int d = 0; d < 4; d++) begin
			if (d != 0)
				set_depth(depth_t'((d + 2) % 4));
			foreach (edge_samples[i])
				send_request(CMD_ENCODE, edge_samples[i], 64'hFFFFFFFFFFFFFFFF, i[0]);
			foreach (edge_pcm[i])
				send_request(CMD_DECODE, 32'hFFFFFFFF, edge_pcm[i], i[0]);
		end

		// Random part: every idling mode meets every format.
		foreach (idle_modes[m]) begin
			send_idle_pct = idle_modes[m][0];
			recv_stall_pct = idle_modes[m][1];
			for (int d = 0; d < 4; d++) begin
				set_depth(depth_t'(d));
				repeat (ITEMS_PER_SETTING)
					send_request(cmd_t'($urandom_range(1)), random_sample(), random_pcm(),
						1'($urandom_range(1)));
			end
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);

		while (pending_count != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### pcm_sample_format_converter_unit.f
rtl/pcmfc_pkg.sv
rtl/pcmfc_enc.sv
rtl/pcmfc_dec.sv
rtl/pcm_sample_format_converter_unit.sv
sim/pcm_conversion_checker.sv
sim/tb.sv
